// File: rtl/bmma_pkg.sv
// Shared types and constants for the block matrix multiply-accumulate unit.
`default_nettype none

package bmma_pkg;

  localparam int ACT_W     = 2;
  localparam int POS_W     = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MUL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b1;

  localparam logic [CFG_W-1:0] MATRIX_SIZE_RST = 5'd16;
  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST  = 5'd4;

  localparam logic KIND_MULT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic ld;
    logic rd_in;
    logic c_rd_ij;
    logic mac_rd;
    logic c_wr_ij;
    logic clr_ovf;
    logic out_read;
    logic out_mult;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/bmma_ctrl.sv
// Sequencer: configuration registers, item decode and the Cannon loop counters.
`default_nettype none

module bmma_ctrl #(
  parameter int MAX_SIZE = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [bmma_pkg::ACT_W-1:0]     action_i,
  output logic                           busy_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [bmma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [bmma_pkg::CFG_W-1:0]     cfg_data_i,
  input  bmma_pkg::status_t              status_i,
  output bmma_pkg::cmd_t                 cmd_o,
  output logic [$clog2(MAX_SIZE)-1:0]    mac_row_o,
  output logic [$clog2(MAX_SIZE)-1:0]    mac_col_o,
  output logic [$clog2(MAX_SIZE)-1:0]    mac_k_o
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int CW = $clog2(MAX_SIZE + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_RDC   = 3'd3;
  localparam logic [2:0] S_ISSUE = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [bmma_pkg::CFG_W-1:0] msize_q, msize_d, bsize_q, bsize_d;
  logic [CW-1:0]             n_q, n_d, bs_q, bs_d, rem_q, rem_d;
  logic [IW-1:0]             i_q, i_d, j_q, j_d, ii_q, ii_d, jj_q, jj_d;
  logic [IW-1:0]             ibase_q, ibase_d, jbase_q, jbase_d;
  logic [IW-1:0]             kbase_q, kbase_d, kk_q, kk_d, t_q, t_d;

  logic [CW-1:0] n_in, n_m1, bs_m1;
  logic          bs_ok, last_i, last_j, last_t, blk_end_i, blk_end_j, blk_end_k;
  logic [CW:0]   ksum, knext_sum, inext_sum, jnext_sum;
  logic [IW-1:0] kstart, knext;

  always_comb begin
    n_in      = (32'(msize_q) > MAX_SIZE) ? CW'(MAX_SIZE) : CW'(msize_q);
    bs_ok     = (bsize_q != '0) && (32'(bsize_q) <= 32'(n_in));
    n_m1      = n_q - CW'(1);
    bs_m1     = bs_q - CW'(1);
    last_i    = (CW'(i_q) == n_m1);
    last_j    = (CW'(j_q) == n_m1);
    last_t    = (CW'(t_q) == n_m1);
    blk_end_i = (CW'(ii_q) == bs_m1);
    blk_end_j = (CW'(jj_q) == bs_m1);
    blk_end_k = (CW'(kk_q) == bs_m1);
    ksum      = (CW+1)'(ibase_q) + (CW+1)'(jbase_q);
    kstart    = (ksum >= (CW+1)'(n_q)) ? IW'(ksum - (CW+1)'(n_q)) : IW'(ksum);
    knext_sum = (CW+1)'(kbase_q) + (CW+1)'(bs_q);
    knext     = (knext_sum >= (CW+1)'(n_q)) ? '0 : IW'(knext_sum);
    inext_sum = (CW+1)'(ibase_q) + (CW+1)'(bs_q);
    jnext_sum = (CW+1)'(jbase_q) + (CW+1)'(bs_q);
  end

  always_comb begin
    state_d = state_q;
    msize_d = msize_q;
    bsize_d = bsize_q;
    n_d     = n_q;
    bs_d    = bs_q;
    rem_d   = rem_q;
    i_d     = i_q;
    j_d     = j_q;
    ii_d    = ii_q;
    jj_d    = jj_q;
    ibase_d = ibase_q;
    jbase_d = jbase_q;
    kbase_d = kbase_q;
    kk_d    = kk_q;
    t_d     = t_q;
    cmd_o   = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bmma_pkg::CFG_MATRIX_SIZE: msize_d = cfg_data_i;
        bmma_pkg::CFG_BLOCK_SIZE:  bsize_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (action_i)
            bmma_pkg::ACT_LOAD: cmd_o.ld = 1'b1;
            bmma_pkg::ACT_READ: begin
              cmd_o.rd_in = 1'b1;
              state_d     = S_READ;
            end
            bmma_pkg::ACT_MUL: begin
              cmd_o.clr_ovf = 1'b1;
              n_d     = n_in;
              i_d     = '0;
              j_d     = '0;
              ii_d    = '0;
              jj_d    = '0;
              ibase_d = '0;
              jbase_d = '0;
              rem_d   = n_in;
              if (n_in == '0) begin
                state_d = S_DONE;
              end else if (bs_ok) begin
                bs_d    = CW'(bsize_q);
                state_d = S_CHK;
              end else begin
                bs_d    = n_in;
                state_d = S_RDC;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.out_read = 1'b1;
        state_d        = S_IDLE;
      end
      S_CHK: begin
        if (rem_q >= bs_q) begin
          rem_d = rem_q - bs_q;
        end else begin
          if (rem_q != '0) begin
            bs_d = n_q;
          end
          state_d = S_RDC;
        end
      end
      S_RDC: begin
        cmd_o.c_rd_ij = 1'b1;
        kbase_d = kstart;
        kk_d    = '0;
        t_d     = '0;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        cmd_o.mac_rd = 1'b1;
        if (blk_end_k) begin
          kk_d    = '0;
          kbase_d = knext;
        end else begin
          kk_d = kk_q + IW'(1);
        end
        t_d = t_q + IW'(1);
        if (last_t) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.pipe_empty) begin
          cmd_o.c_wr_ij = 1'b1;
          state_d       = S_RDC;
          if (last_j) begin
            j_d     = '0;
            jj_d    = '0;
            jbase_d = '0;
            if (last_i) begin
              state_d = S_DONE;
            end else if (blk_end_i) begin
              ii_d    = '0;
              ibase_d = IW'(inext_sum);
              i_d     = i_q + IW'(1);
            end else begin
              ii_d = ii_q + IW'(1);
              i_d  = i_q + IW'(1);
            end
          end else if (blk_end_j) begin
            jj_d    = '0;
            jbase_d = IW'(jnext_sum);
            j_d     = j_q + IW'(1);
          end else begin
            jj_d = jj_q + IW'(1);
            j_d  = j_q + IW'(1);
          end
        end
      end
      S_DONE: begin
        cmd_o.out_mult = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      msize_q <= bmma_pkg::MATRIX_SIZE_RST;
      bsize_q <= bmma_pkg::BLOCK_SIZE_RST;
      n_q     <= '0;
      bs_q    <= '0;
      rem_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ii_q    <= '0;
      jj_q    <= '0;
      ibase_q <= '0;
      jbase_q <= '0;
      kbase_q <= '0;
      kk_q    <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      msize_q <= msize_d;
      bsize_q <= bsize_d;
      n_q     <= n_d;
      bs_q    <= bs_d;
      rem_q   <= rem_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ii_q    <= ii_d;
      jj_q    <= jj_d;
      ibase_q <= ibase_d;
      jbase_q <= jbase_d;
      kbase_q <= kbase_d;
      kk_q    <= kk_d;
      t_q     <= t_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign mac_row_o   = i_q;
  assign mac_col_o   = j_q;
  assign mac_k_o     = kbase_q + kk_q;

  a_bs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (bs_q != '0))
    else $error("block edge zero while issuing");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (CW'(mac_k_o) < n_q))
    else $error("k index beyond matrix size");

  a_chk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |=> (state_q == S_CHK || state_q == S_RDC))
    else $error("divisibility check left to wrong state");

endmodule

`default_nettype wire

// File: rtl/bmma_datapath.sv
// Datapath: A, B and C stores, MAC pipeline with saturating accumulator, result register.
`default_nettype none

module bmma_datapath #(
  parameter int MAX_SIZE  = 16,
  parameter int ELEM_BITS = 16,
  parameter int ACC_BITS  = 40
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  bmma_pkg::cmd_t                      cmd_i,
  output bmma_pkg::status_t                   status_o,
  input  wire  [$clog2(MAX_SIZE)-1:0]         mac_row_i,
  input  wire  [$clog2(MAX_SIZE)-1:0]         mac_col_i,
  input  wire  [$clog2(MAX_SIZE)-1:0]         mac_k_i,
  input  wire  [bmma_pkg::POS_W-1:0]          row_i,
  input  wire  [bmma_pkg::POS_W-1:0]          col_i,
  input  wire  signed [ELEM_BITS-1:0]         a_value_i,
  input  wire  signed [ELEM_BITS-1:0]         b_value_i,
  input  wire  signed [ACC_BITS-1:0]          c_value_i,
  output logic                                result_valid_o,
  output logic signed [ACC_BITS-1:0]          result_value_o,
  output logic                                kind_o,
  output logic                                overflow_o
);

  localparam int IW    = $clog2(MAX_SIZE);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * ELEM_BITS;
  localparam int SW    = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;
  localparam logic signed [SW-1:0] ACC_HI = {{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

  function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
    return AW'(32'(r) * MAX_SIZE + 32'(c));
  endfunction

  logic [ELEM_BITS-1:0] a_mem [DEPTH];
  logic [ELEM_BITS-1:0] b_mem [DEPTH];
  logic [ACC_BITS-1:0]  c_mem [DEPTH];

  logic                        in_range, in_range_q;
  logic [AW-1:0]               in_addr, ij_addr, c_rd_addr, c_wr_addr;
  logic                        c_we;
  logic [ACC_BITS-1:0]         c_wdata;
  logic signed [ELEM_BITS-1:0] a_rd_q, b_rd_q;
  logic [ACC_BITS-1:0]         c_rd_q;
  logic signed [PW-1:0]        prod_q;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d;
  logic                        v1_q, v2_q, ld_acc_q, ovf_q, ovf_d;
  logic signed [SW-1:0]        acc_ext, prod_ext, sum;
  logic                        out_valid_q, kind_q, ovf_out_q;
  logic [ACC_BITS-1:0]         result_q;

  always_comb begin
    in_range  = (32'(row_i) < MAX_SIZE) && (32'(col_i) < MAX_SIZE);
    in_addr   = addr_of(IW'(row_i), IW'(col_i));
    ij_addr   = addr_of(mac_row_i, mac_col_i);
    c_rd_addr = cmd_i.c_rd_ij ? ij_addr : in_addr;
    c_wr_addr = cmd_i.c_wr_ij ? ij_addr : in_addr;
    c_wdata   = cmd_i.c_wr_ij ? acc_q : c_value_i;
    c_we      = cmd_i.c_wr_ij || (cmd_i.ld && in_range);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld && in_range) begin
      a_mem[in_addr] <= a_value_i;
      b_mem[in_addr] <= b_value_i;
    end
    if (c_we) begin
      c_mem[c_wr_addr] <= c_wdata;
    end
    if (cmd_i.mac_rd) begin
      a_rd_q <= a_mem[addr_of(mac_row_i, mac_k_i)];
      b_rd_q <= b_mem[addr_of(mac_k_i, mac_col_i)];
    end
    if (cmd_i.c_rd_ij || cmd_i.rd_in) begin
      c_rd_q <= c_mem[c_rd_addr];
    end
  end

  always_comb begin
    acc_ext  = {{(SW-ACC_BITS){acc_q[ACC_BITS-1]}}, acc_q};
    prod_ext = {{(SW-PW){prod_q[PW-1]}}, prod_q};
    sum      = acc_ext + prod_ext;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    if (cmd_i.clr_ovf) begin
      ovf_d = 1'b0;
    end
    if (ld_acc_q) begin
      acc_d = c_rd_q;
    end else if (v2_q) begin
      if (sum > ACC_HI) begin
        acc_d = ACC_HI[ACC_BITS-1:0];
        ovf_d = 1'b1;
      end else if (sum < ACC_LO) begin
        acc_d = ACC_LO[ACC_BITS-1:0];
        ovf_d = 1'b1;
      end else begin
        acc_d = sum[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_rd_q * b_rd_q;
    acc_q  <= acc_d;
    if (cmd_i.rd_in) begin
      in_range_q <= in_range;
    end
    if (cmd_i.out_read) begin
      result_q <= in_range_q ? c_rd_q : '0;
    end else if (cmd_i.out_mult) begin
      result_q <= '0;
    end
    if (cmd_i.out_read || cmd_i.out_mult) begin
      kind_q    <= cmd_i.out_read ? bmma_pkg::KIND_READ : bmma_pkg::KIND_MULT;
      ovf_out_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      ld_acc_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= cmd_i.mac_rd;
      v2_q        <= v1_q;
      ld_acc_q    <= cmd_i.c_rd_ij;
      ovf_q       <= ovf_d;
      out_valid_q <= cmd_i.out_read || cmd_i.out_mult;
    end
  end

  assign status_o.pipe_empty = !v1_q && !v2_q && !ld_acc_q;
  assign result_valid_o      = out_valid_q;
  assign result_value_o      = result_q;
  assign kind_o              = kind_q;
  assign overflow_o          = ovf_out_q;

  a_wr_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.c_wr_ij |-> (!v1_q && !v2_q))
    else $error("C write-back before MAC pipeline drained");

  a_mult_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == bmma_pkg::KIND_MULT)) |-> (result_q == '0))
    else $error("multiply completion carries non-zero data");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |=> !out_valid_q)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// File: rtl/block_matrix_multiply_accumulate.sv
// Top level: saturating fixed-point matrix multiply-accumulate, C = C + A x B.
// Load: one cycle, no result; the next item may follow at once.
// Read: busy for one cycle after acceptance; result strobe in the cycle after that.
// Multiply (N = matrix size, b = block edge): walks every element of C, with one MAC issue
//   per cycle plus C fetch, drain and write-back per element; the block edge falls back to N
//   when b is zero, above N or does not divide N; strobe follows busy.
// Results are always taken. Reset clears the sequencer and overflow flag, sets matrix
//   size 16 and block edge 4; element stores hold no reset value.
`default_nettype none

module block_matrix_multiply_accumulate #(
  parameter int MAX_SIZE  = 16,
  parameter int ELEM_BITS = 16,
  parameter int ACC_BITS  = 40
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire  [bmma_pkg::ACT_W-1:0]     action_i,
  input  wire  [bmma_pkg::POS_W-1:0]     row_i,
  input  wire  [bmma_pkg::POS_W-1:0]     col_i,
  input  wire  signed [ELEM_BITS-1:0]    a_value_i,
  input  wire  signed [ELEM_BITS-1:0]    b_value_i,
  input  wire  signed [ACC_BITS-1:0]     c_value_i,
  output logic                           result_valid_o,
  output logic signed [ACC_BITS-1:0]     result_value_o,
  output logic                           kind_o,
  output logic                           overflow_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [bmma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [bmma_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int IW = $clog2(MAX_SIZE);

  bmma_pkg::cmd_t    cmd;
  bmma_pkg::status_t status;
  logic [IW-1:0]     mac_row, mac_col, mac_k;

  bmma_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (action_i),
    .busy_o      (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .mac_row_o   (mac_row),
    .mac_col_o   (mac_col),
    .mac_k_o     (mac_k)
  );

  bmma_datapath #(
    .MAX_SIZE  (MAX_SIZE),
    .ELEM_BITS (ELEM_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mac_row_i      (mac_row),
    .mac_col_i      (mac_col),
    .mac_k_i        (mac_k),
    .row_i          (row_i),
    .col_i          (col_i),
    .a_value_i      (a_value_i),
    .b_value_i      (b_value_i),
    .c_value_i      (c_value_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .kind_o         (kind_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire
